### hdl/nlhx_pkg.sv
// Shared types and constants for the notify-line hex extractor.
// Depends on nothing; every module of the block imports it.
package nlhx_pkg;

   // Default depth of the line store.
   localparam int LINE_DEPTH_DEF = 64;

   // Line framing constants.
   localparam int HDR_SKIP    = 10;
   localparam int DATA_OFFSET = 8;
   localparam int MAX_PAIRS   = 26;

   // Characters that the sequencer looks for.
   localparam logic [7:0] CHAR_W       = 8'h57;
   localparam logic [7:0] CHAR_V       = 8'h56;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Input item kinds.
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // Input beat payload.
   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   // Result beat payload.
   typedef struct packed {
      logic [7:0] data_byte;
      logic [4:0] byte_position;
      logic       last;
   } rsp_type;

   // Classification of one character by the hex digit unit.
   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

endpackage

### hdl/nlhx_hex_unit.sv
// Hex digit unit: classifies one character as a hex digit and gives its value.
// Depends on nlhx_pkg for the hex_type result struct.
module nlhx_hex_unit
   import nlhx_pkg::*;
(
   input  logic [7:0] char_in,
   output hex_type    digit
);

   // Decimal digits, then lower and upper case letters a to f.
   always_comb begin
      digit.ok     = 1'b0;
      digit.nibble = 4'd0;
      if (char_in >= 8'h30 && char_in <= 8'h39) begin
         digit.ok     = 1'b1;
         digit.nibble = 4'(char_in - 8'h30);
      end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
         digit.ok     = 1'b1;
         digit.nibble = 4'(char_in - 8'h57);
      end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
         digit.ok     = 1'b1;
         digit.nibble = 4'(char_in - 8'h37);
      end
   end

endmodule

### hdl/nlhx_line_store.sv
// Line store: byte memory with one write and one registered read port.
// Entries never written read as zero through per-entry valid bits.
// Depends on nlhx_pkg for the default depth.
module nlhx_line_store
   import nlhx_pkg::*;
#(
   parameter int DEPTH = LINE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;

   // Storage array write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Valid bits: cleared by reset, set by the first write of an entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : 8'h00;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/notify_line_hex_extractor.sv
// Flow: a newline with a valid header runs the header check through S_H0 to S_H3,
// then gives one result per pair through S_RHI, S_RLO and S_DEC; S_DEC holds on rsp_stall.
// Throughput: one item per cycle outside line handling, since the single store read
// port and the shared hex digit unit are used by the header check and by each pair.
// Reset: synchronous, clears the fill index, pending flag, sequencer and store valid bits.
module notify_line_hex_extractor
   import nlhx_pkg::*;
#(
   parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int FILL_W = $clog2(LINE_DEPTH);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_H0   = 3'd1;
   localparam logic [2:0] S_H1   = 3'd2;
   localparam logic [2:0] S_H2   = 3'd3;
   localparam logic [2:0] S_H3   = 3'd4;
   localparam logic [2:0] S_RHI  = 3'd5;
   localparam logic [2:0] S_RLO  = 3'd6;
   localparam logic [2:0] S_DEC  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              pending_ff, pending_in;
   logic [4:0]        pair_cnt_ff, pair_cnt_in;
   logic [4:0]        pair_idx_ff, pair_idx_in;
   hex_type           hi_ff, hi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_take;
   logic              wr_en;
   logic              rd_en;
   logic [FILL_W-1:0] rd_addr;
   logic [FILL_W-1:0] pair_addr;
   logic [7:0]        rd_data;
   hex_type           digit;
   logic              load_ok;
   logic              last_pair;
   logic [7:0]        pair_value;
   logic [FILL_W:0]   fill_diff;
   logic [8:0]        half_ext;
   logic [4:0]        pairs_new;

   // Line store and the shared hex digit unit.
   nlhx_line_store #(
      .DEPTH (LINE_DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_data.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nlhx_hex_unit u_hex (
      .char_in (rd_data),
      .digit   (digit)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign wr_en     = req_take && (req_data.kind == KIND_BYTE) && !pending_ff
                      && (req_data.rx_byte != CHAR_NEWLINE);

   // Pair count from the fill index at the newline, capped.
   assign fill_diff = {1'b0, fill_ff} - (FILL_W + 1)'(HDR_SKIP);
   assign half_ext  = 9'(fill_diff >> 1);
   always_comb begin
      if (fill_ff < FILL_W'(HDR_SKIP)) begin
         pairs_new = 5'd0;
      end else if (half_ext > 9'(MAX_PAIRS)) begin
         pairs_new = 5'(MAX_PAIRS);
      end else begin
         pairs_new = half_ext[4:0];
      end
   end

   // Store read address for each sequencer step.
   assign pair_addr = FILL_W'(DATA_OFFSET) + FILL_W'({pair_idx_ff, 1'b0});
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      unique case (state_ff)
         S_H0:    rd_addr = FILL_W'(0);
         S_H1:    rd_addr = FILL_W'(1);
         S_H2:    rd_addr = FILL_W'(2);
         S_RHI:   rd_addr = pair_addr;
         S_RLO:   rd_addr = pair_addr + FILL_W'(1);
         default: rd_en   = 1'b0;
      endcase
   end

   // Pair value from the stored high digit and the current low digit.
   always_comb begin
      if (!hi_ff.ok) begin
         pair_value = 8'h00;
      end else if (!digit.ok) begin
         pair_value = {4'd0, hi_ff.nibble};
      end else begin
         pair_value = {hi_ff.nibble, digit.nibble};
      end
   end

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign last_pair = (pair_idx_ff + 5'd1) == pair_cnt_ff;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      pending_in   = pending_ff;
      pair_cnt_in  = pair_cnt_ff;
      pair_idx_in  = pair_idx_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_RELEASE) begin
                  pending_in = 1'b0;
               end else if (!pending_ff) begin
                  if (req_data.rx_byte == CHAR_NEWLINE) begin
                     pair_cnt_in = pairs_new;
                     pair_idx_in = 5'd0;
                     fill_in     = '0;
                     state_in    = S_H0;
                  end else if (fill_ff == FILL_W'(LINE_DEPTH - 1)) begin
                     fill_in = '0;
                  end else begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
         end
         S_H0: begin
            state_in = S_H1;
         end
         S_H1: begin
            state_in = (rd_data == CHAR_W) ? S_H2 : S_IDLE;
         end
         S_H2: begin
            state_in = (rd_data == CHAR_V) ? S_H3 : S_IDLE;
         end
         S_H3: begin
            state_in = (rd_data == CHAR_COMMA && pair_cnt_ff != 5'd0) ? S_RHI : S_IDLE;
         end
         S_RHI: begin
            state_in = S_RLO;
         end
         S_RLO: begin
            hi_in    = digit;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (load_ok) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.data_byte     = pair_value;
               rsp_data_in.byte_position = pair_idx_ff;
               rsp_data_in.last          = last_pair;
               if (last_pair) begin
                  pending_in = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  pair_idx_in = pair_idx_ff + 5'd1;
                  state_in    = S_RHI;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and loop registers.
   always_ff @(posedge clock) begin
      pair_cnt_ff <= pair_cnt_in;
      pair_idx_ff <= pair_idx_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A new result appears only from the decode step.
   a_rsp_from_dec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DEC)
      else $error("result appeared outside the decode step");

   // The final pair of a line sets the pending flag.
   a_last_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC && load_ok && last_pair) |=> pending_ff)
      else $error("pending not set after the final pair");

   // The pair loop never runs past the pair count.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RHI) |-> (pair_idx_ff < pair_cnt_ff))
      else $error("pair index beyond pair count");

   // A loaded result carries the last mark only on the final pair.
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC && load_ok) |=> (rsp_data_ff.last == (state_ff == S_IDLE)))
      else $error("last mark does not match loop end");
`endif

endmodule
